// File: src/uer_pkg.sv
package uer_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DIST_W      = 16;
  localparam int TRIG_W      = 8;
  localparam int LIMIT_W     = 16;
  localparam int DIV_W       = 8;
  localparam int QW          = (COUNT_WIDTH > DIST_W) ? COUNT_WIDTH : DIST_W;
  localparam int DIV_CNT_W   = $clog2(COUNT_WIDTH + 1);

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_WIDTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_LIMIT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_DIVISOR = 2'd2;

  localparam logic [TRIG_W-1:0]  TRIGGER_WIDTH_RST = 8'd10;
  localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = 16'd30000;
  localparam logic [DIV_W-1:0]   RANGE_DIVISOR_RST = 8'd58;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CT_WAIT_IN = 2'd0,
    CT_DIVIDE  = 2'd1,
    CT_EMIT    = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic tick;
    logic div_start;
    logic commit;
  } uer_cmd_t;

  typedef struct packed {
    logic phase_done;
    logic div_done;
  } uer_stat_t;

endpackage

// File: src/uer_div.sv
module uer_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [uer_pkg::COUNT_WIDTH-1:0]  dividend,
  input  logic [uer_pkg::DIV_W-1:0]        divisor,
  output logic                             done,
  output logic [uer_pkg::COUNT_WIDTH-1:0]  quotient
);
  import uer_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]       rem_r, rem_nxt;
  logic [DIV_W-1:0]       dsr_r, dsr_nxt;
  logic [COUNT_WIDTH-1:0] quo_r, quo_nxt;
  logic [DIV_W:0]         trial;
  logic [DIV_W:0]         diff;

  assign trial = {rem_r, quo_r[COUNT_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(COUNT_WIDTH);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[COUNT_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[COUNT_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/uer_dp.sv
module uer_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [uer_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [uer_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  uer_pkg::uer_cmd_t                cmd,
  output uer_pkg::uer_stat_t               stat,
  output logic [uer_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import uer_pkg::*;

  logic [TRIG_W-1:0]      trigger_width_r;
  logic [LIMIT_W-1:0]     timeout_limit_r;
  logic [DIV_W-1:0]       range_divisor_r;

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_WIDTH-1:0] rise_stamp_r, rise_stamp_nxt;
  logic [COUNT_WIDTH-1:0] fall_stamp_r, fall_stamp_nxt;
  logic [TRIG_W-1:0]      trig_left_r, trig_left_nxt;
  logic                   ready_r, ready_nxt;
  logic [DIST_W-1:0]      dist_r, dist_nxt;
  logic                   valid_r, valid_nxt;

  logic                   start_req, echo_rise, echo_fall, read_ack;
  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic                   timed_out;
  logic                   div_done;
  logic [COUNT_WIDTH-1:0] quotient;
  logic [QW-1:0]          quo_wide;
  logic [DIST_W-1:0]      dist_calc;

  assign start_req = in_tdata[0];
  assign echo_rise = in_tdata[1];
  assign echo_fall = in_tdata[2];
  assign read_ack  = in_tdata[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_width_r <= TRIGGER_WIDTH_RST;
      timeout_limit_r <= TIMEOUT_LIMIT_RST;
      range_divisor_r <= RANGE_DIVISOR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TRIGGER_WIDTH: trigger_width_r <= cfg_wdata[TRIG_W-1:0];
        REG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_RANGE_DIVISOR: range_divisor_r <= cfg_wdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  uer_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (fall_stamp_r - rise_stamp_r),
    .divisor  (range_divisor_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign quo_wide  = QW'(quotient);
  assign dist_calc = (range_divisor_r == '0 || quo_wide > QW'(DIST_MAX)) ?
                     DIST_MAX : quo_wide[DIST_W-1:0];

  assign elapsed_inc = ((phase_r == PH_RISE || phase_r == PH_FALL) &&
                        elapsed_r != COUNT_MAX) ? elapsed_r + 1'b1 : elapsed_r;
  assign timed_out   = QW'(elapsed_inc) > QW'(timeout_limit_r);

  always_comb begin
    phase_nxt      = phase_r;
    elapsed_nxt    = elapsed_r;
    rise_stamp_nxt = rise_stamp_r;
    fall_stamp_nxt = fall_stamp_r;
    trig_left_nxt  = trig_left_r;
    ready_nxt      = ready_r;
    dist_nxt       = dist_r;
    valid_nxt      = valid_r;
    if (cmd.tick) begin
      trig_left_nxt = (trig_left_r != '0) ? trig_left_r - 1'b1 : trig_left_r;
      elapsed_nxt   = elapsed_inc;
      ready_nxt     = read_ack ? 1'b0 : ready_r;
      case (phase_r)
        PH_IDLE: begin
          if (start_req) begin
            rise_stamp_nxt = '0;
            fall_stamp_nxt = '0;
            dist_nxt       = '0;
            valid_nxt      = 1'b0;
            ready_nxt      = 1'b0;
            elapsed_nxt    = '0;
            trig_left_nxt  = trigger_width_r;
            phase_nxt      = PH_RISE;
          end
        end
        PH_RISE: begin
          if (timed_out) begin
            ready_nxt = 1'b1;
            valid_nxt = 1'b0;
            dist_nxt  = '0;
            phase_nxt = PH_IDLE;
          end else if (echo_rise) begin
            rise_stamp_nxt = elapsed_inc;
            phase_nxt      = PH_FALL;
          end
        end
        PH_FALL: begin
          if (timed_out) begin
            ready_nxt = 1'b1;
            valid_nxt = 1'b0;
            dist_nxt  = '0;
            phase_nxt = PH_IDLE;
          end else if (echo_fall) begin
            fall_stamp_nxt = elapsed_inc;
            phase_nxt      = PH_DONE;
          end
        end
        default: ;
      endcase
    end else if (cmd.commit) begin
      dist_nxt  = dist_calc;
      valid_nxt = 1'b1;
      ready_nxt = 1'b1;
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      elapsed_r    <= '0;
      rise_stamp_r <= '0;
      fall_stamp_r <= '0;
      trig_left_r  <= '0;
      ready_r      <= 1'b0;
      dist_r       <= '0;
      valid_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      elapsed_r    <= elapsed_nxt;
      rise_stamp_r <= rise_stamp_nxt;
      fall_stamp_r <= fall_stamp_nxt;
      trig_left_r  <= trig_left_nxt;
      ready_r      <= ready_nxt;
      dist_r       <= dist_nxt;
      valid_r      <= valid_nxt;
    end
  end

  assign stat.phase_done = (phase_r == PH_DONE);
  assign stat.div_done   = div_done;

  assign out_tdata = {3'b000, phase_r, valid_r, dist_r, ready_r, (trig_left_r != '0)};

endmodule

// File: src/uer_ctrl.sv
module uer_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  uer_pkg::uer_stat_t stat,
  output uer_pkg::uer_cmd_t  cmd
);
  import uer_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CT_WAIT_IN: begin
        if (in_tvalid) begin
          state_nxt = stat.phase_done ? CT_DIVIDE : CT_EMIT;
        end
      end
      CT_DIVIDE: begin
        if (stat.div_done) begin
          state_nxt = CT_EMIT;
        end
      end
      CT_EMIT: begin
        if (out_tready) begin
          state_nxt = CT_WAIT_IN;
        end
      end
      default: state_nxt = CT_WAIT_IN;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    cmd.tick      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      CT_WAIT_IN: begin
        in_tready     = 1'b1;
        cmd.tick      = in_tvalid;
        cmd.div_start = in_tvalid & stat.phase_done;
      end
      CT_DIVIDE: begin
        cmd.commit = stat.div_done;
      end
      CT_EMIT: begin
        out_tvalid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CT_WAIT_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/ultrasonic_echo_ranger_core.sv
// Pulse-width ranging for a trigger/echo ultrasonic sensor. Each input transaction is one
// microsecond tick and returns exactly one output transaction with the trigger level, the
// ready flag, the distance in centimeters, its valid flag and the current phase. A tick
// goes to the emit state and waits there while the output side is not ready; the tick
// after a captured falling edge first passes a divide state, where the restoring divider
// gives one quotient bit per cycle. Configuration is written through cfg_we, cfg_addr
// and cfg_wdata; the user must do so only while idle, as the block does not enforce it.
module ultrasonic_echo_ranger_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [uer_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: start_request, echo_rise, echo_fall, read_ack, zero fill.
  input  logic [uer_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: trigger_level, result_ready, distance_cm[15:0], distance_valid,
  // phase[1:0], zero fill.
  output logic [uer_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import uer_pkg::*;

  uer_cmd_t  cmd;
  uer_stat_t stat;

  uer_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  uer_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

// File: test/tb_ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_core;
  import uer_pkg::*;

  localparam logic [3:0] F_NONE  = 4'b0000;
  localparam logic [3:0] F_START = 4'b0001;
  localparam logic [3:0] F_RISE  = 4'b0010;
  localparam logic [3:0] F_FALL  = 4'b0100;
  localparam logic [3:0] F_ACK   = 4'b1000;
  localparam logic [3:0] F_ALL   = 4'b1111;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER = 250;
  localparam int CYCLE_LIMIT = 25000000;

  typedef struct packed {
    phase_t            phase;
    logic              valid;
    logic [DIST_W-1:0] dist_cm;
    logic              ready;
    logic              trig;
  } reading_t;

  typedef enum {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    logic [3:0]            flags;
    int                    reps;
    bit                    typed;
    reading_t              want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  ultrasonic_echo_ranger_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  logic [TRIG_W-1:0]      trig_width;
  logic [LIMIT_W-1:0]     time_limit;
  logic [DIV_W-1:0]       divisor;
  phase_t                 cur_phase;
  logic [COUNT_WIDTH-1:0] elapsed;
  logic [COUNT_WIDTH-1:0] rise_at;
  logic [COUNT_WIDTH-1:0] fall_at;
  logic [TRIG_W-1:0]      trig_remaining;
  logic                   rdy;
  logic [DIST_W-1:0]      dist_val;
  logic                   dist_ok;

  reading_t  readings_due[$];
  plan_row_t plan[$];
  int        errors = 0;
  int        readings_seen = 0;
  int        cycle_cnt = 0;
  bit        held_off = 1'b0;
  reading_t  got;
  reading_t  want;

  function automatic reading_t next_reading(logic [3:0] f);
    reading_t               r;
    logic [COUNT_WIDTH-1:0] span;
    logic [QW-1:0]          quo;
    if (trig_remaining != 0) trig_remaining = trig_remaining - 1'b1;
    if ((cur_phase == PH_RISE || cur_phase == PH_FALL) && elapsed != COUNT_MAX) begin
      elapsed = elapsed + 1'b1;
    end
    if ((f & F_ACK) != 0) rdy = 1'b0;
    case (cur_phase)
      PH_IDLE: begin
        if ((f & F_START) != 0) begin
          rise_at = '0;
          fall_at = '0;
          dist_val = '0;
          dist_ok = 1'b0;
          rdy = 1'b0;
          elapsed = '0;
          trig_remaining = trig_width;
          cur_phase = PH_RISE;
        end
      end
      PH_RISE, PH_FALL: begin
        if (elapsed > time_limit) begin
          rdy = 1'b1;
          dist_ok = 1'b0;
          dist_val = '0;
          cur_phase = PH_IDLE;
        end else if (cur_phase == PH_RISE && (f & F_RISE) != 0) begin
          rise_at = elapsed;
          cur_phase = PH_FALL;
        end else if (cur_phase == PH_FALL && (f & F_FALL) != 0) begin
          fall_at = elapsed;
          cur_phase = PH_DONE;
        end
      end
      default: begin
        span = fall_at - rise_at;
        if (divisor == 0) begin
          dist_val = DIST_MAX;
        end else begin
          quo = QW'(span) / QW'(divisor);
          dist_val = (quo > QW'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];
        end
        dist_ok = 1'b1;
        rdy = 1'b1;
        cur_phase = PH_IDLE;
      end
    endcase
    r.trig = (trig_remaining != 0);
    r.ready = rdy;
    r.dist_cm = dist_val;
    r.valid = dist_ok;
    r.phase = cur_phase;
    return r;
  endfunction

  function automatic int idle_len(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [3:0] random_tick();
    logic [3:0] f;
    f = F_NONE;
    if ($urandom_range(0, 99) < 15) return 4'($urandom_range(0, 15));
    case (cur_phase)
      PH_IDLE: if ($urandom_range(0, 2) == 0) f = f | F_START;
      PH_RISE: if ($urandom_range(0, 5) == 0) f = f | F_RISE;
      PH_FALL: if ($urandom_range(0, 5) == 0) f = f | F_FALL;
      default: if ($urandom_range(0, 3) == 0) f = f | F_START;
    endcase
    if ($urandom_range(0, 4) == 0) f = f | F_ACK;
    return f;
  endfunction

  function automatic void add_row(row_kind_t k, logic [CFG_ADDR_W-1:0] a,
                                  logic [CFG_DATA_W-1:0] d, logic [3:0] f, int n,
                                  bit typed, reading_t w);
    plan_row_t row;
    row.kind = k;
    row.addr = a;
    row.data = d;
    row.flags = f;
    row.reps = n;
    row.typed = typed;
    row.want = w;
    plan.push_back(row);
  endfunction

  function automatic reading_t reading(phase_t ph, logic v, logic [DIST_W-1:0] d,
                                       logic rd, logic t);
    reading_t r;
    r.phase = ph;
    r.valid = v;
    r.dist_cm = d;
    r.ready = rd;
    r.trig = t;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (a)
      REG_TRIGGER_WIDTH: trig_width = d[TRIG_W-1:0];
      REG_TIMEOUT_LIMIT: time_limit = d[LIMIT_W-1:0];
      REG_RANGE_DIVISOR: divisor = d[DIV_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_tick(input logic [3:0] f, input bit typed, input reading_t w);
    int       g;
    reading_t r;
    g = idle_len(cycle_cnt[11:10] == 2'b01);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(f);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = next_reading(f);
    readings_due.push_back(typed ? w : r);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      readings_seen++;
      got = reading_t'(out_tdata[20:0]);
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, got %h", $time, out_tdata);
      end else begin
        want = readings_due.pop_front();
        if (got.trig !== want.trig) begin
          errors++;
          $display("%0t: trigger_level expected %0d got %0d", $time, want.trig, got.trig);
        end
        if (got.ready !== want.ready) begin
          errors++;
          $display("%0t: result_ready expected %0d got %0d", $time, want.ready, got.ready);
        end
        if (got.dist_cm !== want.dist_cm) begin
          errors++;
          $display("%0t: distance_cm expected %0d got %0d", $time, want.dist_cm,
                   got.dist_cm);
        end
        if (got.valid !== want.valid) begin
          errors++;
          $display("%0t: distance_valid expected %0d got %0d", $time, want.valid, got.valid);
        end
        if (got.phase !== want.phase) begin
          errors++;
          $display("%0t: phase expected %0d got %0d", $time, want.phase, got.phase);
        end
      end
    end
  end

  initial begin
    int g;
    forever begin
      if (!held_off && readings_seen >= HOLD_OFF_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      g = idle_len(cycle_cnt[10:9] == 2'b11);
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    reading_t zero_rd;
    logic [TRIG_W-1:0]  tw;
    logic [LIMIT_W-1:0] tl;
    logic [DIV_W-1:0]   dv;
    zero_rd = reading(PH_IDLE, 1'b0, '0, 1'b0, 1'b0);
    trig_width = TRIGGER_WIDTH_RST;
    time_limit = TIMEOUT_LIMIT_RST;
    divisor = RANGE_DIVISOR_RST;
    cur_phase = PH_IDLE;
    elapsed = '0;
    rise_at = '0;
    fall_at = '0;
    trig_remaining = '0;
    rdy = 1'b0;
    dist_val = '0;
    dist_ok = 1'b0;

    add_row(ROW_TICK, '0, '0, F_NONE, 1, 1'b1, zero_rd);
    add_row(ROW_TICK, '0, '0, F_ACK, 1, 1'b1, zero_rd);
    add_row(ROW_TICK, '0, '0, F_RISE | F_FALL, 1, 1'b1, zero_rd);
    add_row(ROW_TICK, '0, '0, F_START, 1, 1'b1, reading(PH_RISE, 1'b0, '0, 1'b0, 1'b1));
    add_row(ROW_TICK, '0, '0, F_START | F_FALL, 3, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_RISE | F_FALL, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_NONE, 200, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_START | F_RISE | F_FALL, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_START, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_ACK, 1, 1'b0, zero_rd);
    add_row(ROW_CFG, REG_TRIGGER_WIDTH, '0, F_NONE, 0, 1'b0, zero_rd);
    add_row(ROW_CFG, REG_RANGE_DIVISOR, '0, F_NONE, 0, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_ALL, 1, 1'b1, reading(PH_RISE, 1'b0, '0, 1'b0, 1'b0));
    add_row(ROW_TICK, '0, '0, F_RISE, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_NONE, 2, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_FALL, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_ACK, 1, 1'b1, reading(PH_IDLE, 1'b1, DIST_MAX, 1'b1, 1'b0));
    add_row(ROW_CFG, REG_TIMEOUT_LIMIT, 16'd1, F_NONE, 0, 1'b0, zero_rd);
    add_row(ROW_CFG, REG_TRIGGER_WIDTH, 16'hFF05, F_NONE, 0, 1'b0, zero_rd);
    add_row(ROW_CFG, REG_UNUSED, 16'hFFFF, F_NONE, 0, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_START, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_NONE, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_ACK, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_START, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_RISE, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_NONE, 2, 1'b0, zero_rd);
    add_row(ROW_CFG, REG_TIMEOUT_LIMIT, 16'hFFFF, F_NONE, 0, 1'b0, zero_rd);
    add_row(ROW_CFG, REG_RANGE_DIVISOR, 16'd1, F_NONE, 0, 1'b0, zero_rd);
    add_row(ROW_CFG, REG_TRIGGER_WIDTH, 16'd255, F_NONE, 0, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_START, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_RISE, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_NONE, 40, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_FALL, 1, 1'b0, zero_rd);
    add_row(ROW_TICK, '0, '0, F_NONE, 1, 1'b0, zero_rd);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        repeat (plan[i].reps) send_tick(plan[i].flags, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          tw = 8'd1;
          tl = 16'd1;
          dv = 8'd1;
        end
        1: begin
          tw = 8'd255;
          tl = 16'd65534;
          dv = 8'd255;
        end
        default: begin
          tw = TRIG_W'($urandom_range(1, 20));
          tl = LIMIT_W'($urandom_range(10, 300));
          dv = ($urandom_range(0, 3) == 0) ? DIV_W'($urandom_range(1, 255))
                                           : DIV_W'($urandom_range(1, 16));
        end
      endcase
      write_reg(REG_TRIGGER_WIDTH, CFG_DATA_W'(tw));
      write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'(tl));
      write_reg(REG_RANGE_DIVISOR, CFG_DATA_W'(dv));
      repeat (48) send_tick(random_tick(), 1'b0, zero_rd);
    end

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/uer_pkg.sv
src/uer_div.sv
src/uer_dp.sv
src/uer_ctrl.sv
src/ultrasonic_echo_ranger_core.sv
test/tb_ultrasonic_echo_ranger_core.sv
